FILE: design/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, codes and defaults of the multi-stack engine.
// ----------------------------------------------------------------------------
package mse_pkg;

  // Default build parameters
  localparam int NUM_STACKS_DEF = 4;
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int OPCODE_W = 2;
  localparam int SEL_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Configuration register file
  localparam int NUM_CAPS  = 4;
  localparam int ACTIVE_W  = 3;
  localparam int CAP_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAP2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAP3   = 3'd4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 3'd4;
  localparam logic [CAP_W-1:0]    CAP_RST    = 5'd16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [SEL_W-1:0]          stack_select;
    logic signed [VALUE_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    status_e                   status;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic issue;  // transaction accepted: decode, store access, count update
    logic load;   // capture the result into the output register
  } cmd_t;

endpackage

FILE: design/mse_stream_if.sv
// ----------------------------------------------------------------------------
// mse_stream_if
// Valid/ready channel carrying one payload word per transaction.
// ----------------------------------------------------------------------------
interface mse_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(WORDS)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(WORDS)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [WORDS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer: accepts a transaction, waits for store data, loads the result.
// ----------------------------------------------------------------------------
module mse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mse_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_RESULT = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o.issue = 1'b0;
    cmd_o.load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.issue = 1'b1;
          state_d     = S_RESULT;
        end
      end
      S_RESULT: begin
        // store read data is valid here; wait for room in the output reg
        if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/mse_dp.sv
// ----------------------------------------------------------------------------
// mse_dp
// Datapath: configuration registers, fill counts, stack store, result reg.
// ----------------------------------------------------------------------------
module mse_dp #(
  parameter int NUM_STACKS = mse_pkg::NUM_STACKS_DEF,
  parameter int DEPTH      = mse_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mse_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mse_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  mse_pkg::cmd_t                    cmd_i,
  input  mse_pkg::req_t                    req_i,
  output mse_pkg::rsp_t                    rsp_o
);

  localparam int WORDS  = NUM_STACKS * DEPTH;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CMP_W  = (CNT_W > mse_pkg::CAP_W) ? CNT_W : mse_pkg::CAP_W;
  localparam logic [3:0]       NUM_STACKS_L = 4'(NUM_STACKS);
  localparam logic [CMP_W-1:0] DEPTH_L      = CMP_W'(DEPTH);

  // Configuration
  logic [mse_pkg::ACTIVE_W-1:0] active_q;
  logic [mse_pkg::CAP_W-1:0]    cap_q [mse_pkg::NUM_CAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= mse_pkg::ACTIVE_RST;
      for (int i = 0; i < mse_pkg::NUM_CAPS; i++) begin
        cap_q[i] <= mse_pkg::CAP_RST;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mse_pkg::REG_ACTIVE: active_q <= cfg_wdata_i[mse_pkg::ACTIVE_W-1:0];
        mse_pkg::REG_CAP0:   cap_q[0] <= cfg_wdata_i;
        mse_pkg::REG_CAP1:   cap_q[1] <= cfg_wdata_i;
        mse_pkg::REG_CAP2:   cap_q[2] <= cfg_wdata_i;
        mse_pkg::REG_CAP3:   cap_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Decode
  logic [CNT_W-1:0]  fill_q [NUM_STACKS];
  logic [IDX_W-1:0]  sel_idx;
  logic              sel_bad;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_nx;
  logic              fill_upd;
  logic [CMP_W-1:0]  cap_raw;
  logic [CMP_W-1:0]  cap_lim;
  logic              full;
  logic [ADDR_W-1:0] base;
  logic              ram_we;
  logic              ram_re;
  mse_pkg::status_e  status_d;

  assign sel_idx = IDX_W'(req_i.stack_select);
  assign sel_bad = ({1'b0, req_i.stack_select} >= active_q)
                || (4'(req_i.stack_select) >= NUM_STACKS_L);
  assign fill    = sel_bad ? '0 : fill_q[sel_idx];
  assign cap_raw = CMP_W'(cap_q[req_i.stack_select]);
  assign cap_lim = (cap_raw > DEPTH_L) ? DEPTH_L : cap_raw;
  assign full    = (CMP_W'(fill) >= cap_lim) || (CMP_W'(fill) >= DEPTH_L);
  assign base    = ADDR_W'(sel_idx) * ADDR_W'(DEPTH);

  always_comb begin
    status_d = mse_pkg::ST_OK;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    fill_upd = 1'b0;
    fill_nx  = fill;
    if (sel_bad) begin
      status_d = mse_pkg::ST_INVALID;
    end else begin
      unique case (req_i.opcode)
        mse_pkg::OP_PUSH: begin
          if (full) begin
            status_d = mse_pkg::ST_OVERFLOW;
          end else begin
            ram_we   = 1'b1;
            fill_upd = 1'b1;
            fill_nx  = fill + CNT_W'(1);
          end
        end
        mse_pkg::OP_POP, mse_pkg::OP_PEEK: begin
          if (fill == '0) begin
            status_d = mse_pkg::ST_UNDERFLOW;
          end else begin
            ram_re = 1'b1;
            if (req_i.opcode == mse_pkg::OP_POP) begin
              fill_upd = 1'b1;
              fill_nx  = fill - CNT_W'(1);
            end
          end
        end
        default: begin
          status_d = mse_pkg::ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cmd_i.issue && fill_upd) begin
      fill_q[sel_idx] <= fill_nx;
    end
  end

  // Stack store
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;
  logic [DATA_WIDTH-1:0] rdata;

  assign waddr = base + ADDR_W'(fill);
  assign raddr = base + ADDR_W'(fill - CNT_W'(1));

  mse_ram #(
    .WIDTH (DATA_WIDTH),
    .WORDS (WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.issue && ram_we),
    .waddr_i (waddr),
    .wdata_i (DATA_WIDTH'($unsigned(req_i.push_value))),
    .re_i    (cmd_i.issue && ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Per-transaction result info, held until load
  mse_pkg::status_e status_q;
  logic             from_ram_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      status_q   <= status_d;
      from_ram_q <= ram_re;
    end
  end

  // Result
  logic signed [63:0]              rd_ext;
  logic signed [mse_pkg::VALUE_W-1:0] rd_val;
  mse_pkg::rsp_t                   rsp_q;

  assign rd_ext = 64'($signed(rdata));

  always_comb begin
    if (from_ram_q) begin
      rd_val = rd_ext[mse_pkg::VALUE_W-1:0];
    end else if (status_q == mse_pkg::ST_UNDERFLOW) begin
      rd_val = '1;
    end else begin
      rd_val = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rsp_q.read_value <= rd_val;
      rsp_q.status     <= status_q;
    end
  end

  assign rsp_o = rsp_q;

endmodule

FILE: design/multi_stack_engine.sv
// ----------------------------------------------------------------------------
// multi_stack_engine
// Several bounded LIFO stacks sharing one store, push/pop/peek per request.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  --------  ----  -----------------  ----------------------------------------
//  req_if    in    valid/ready        opcode, stack_select, push_value
//  rsp_if    out   valid/ready        read_value, status
//  cfg       in    cfg_we_i (no wait) cfg_index_i, cfg_wdata_i
//
//  In the accept cycle a transaction is decoded, its fill count updated and
//  the store write or read started; in the result state the registered store
//  read data is taken into the output register once that register has room.
//  The store has one read port with registered read data.
//  Reset restores configuration defaults and empties every stack; the store
//  itself needs no clearing, since only written entries are ever read.
//  req_if is not ready in the cycle after each accept, and stays low while a
//  finished result waits for the output register to drain.
//
module multi_stack_engine #(
  parameter int NUM_STACKS = mse_pkg::NUM_STACKS_DEF,  // 1..8
  parameter int DEPTH      = mse_pkg::DEPTH_DEF,       // 2..1024 words/stack
  parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEF   // 8..64 stored bits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes, only while idle
  input  logic                           cfg_we_i,
  input  logic [mse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mse_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // request and response channels
  mse_stream_if.sink                     req_if,
  mse_stream_if.source                   rsp_if
);

  mse_pkg::cmd_t cmd;    // controller -> datapath
  mse_pkg::req_t req;
  mse_pkg::rsp_t rsp;

  assign req = req_if.data;

  // Sequencer owns both handshakes; datapath never sees valid/ready
  mse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_if.valid),
    .in_ready_o  (req_if.ready),
    .out_valid_o (rsp_if.valid),
    .out_ready_i (rsp_if.ready),
    .cmd_o       (cmd)
  );

  // Config regs, fill counts, stack store and result register
  mse_dp #(
    .NUM_STACKS (NUM_STACKS),
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  assign rsp_if.data = rsp;

endmodule

FILE: bench/mse_checker.sv
// ----------------------------------------------------------------------------
// mse_checker
// Watches the request, response and configuration ports of the multi-stack
// engine, keeps its own copy of the stacks and registers, and compares each
// response with the oldest predicted one.
// ----------------------------------------------------------------------------
module mse_checker
  import mse_pkg::*;
#(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int DEPTH      = DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  req_t                 req_data_i,
  input  logic                 rsp_valid_i,
  input  logic                 rsp_ready_i,
  input  rsp_t                 rsp_data_i,
  output int                   pending_o,
  output int                   errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [VALUE_W-1:0]  word_store [NUM_STACKS*DEPTH];
  int unsigned         fill_level [NUM_STACKS];
  logic [ACTIVE_W-1:0] active_cnt;
  logic [CAP_W-1:0]    cap_reg [NUM_CAPS];
  rsp_t                expected_q [$];
  rsp_t                want;
  int                  fails = 0;

  // Applies one operation to the mirrored stacks and returns its response
  function automatic rsp_t apply_stack_op(req_t r);
    rsp_t        res;
    int unsigned usable;
    int unsigned sel;
    int unsigned fill;
    int unsigned limit;
    res.read_value = '0;
    res.status     = ST_OK;
    usable = (active_cnt > NUM_STACKS) ? NUM_STACKS : active_cnt;
    sel    = r.stack_select;
    if (sel >= usable) begin
      res.status = ST_INVALID;
    end else begin
      fill  = fill_level[sel];
      limit = (sel < NUM_CAPS) ? cap_reg[sel] : 0;
      if (limit > DEPTH) limit = DEPTH;
      case (r.opcode)
        OP_PUSH: begin
          if (fill >= limit) begin
            res.status = ST_OVERFLOW;
          end else begin
            word_store[sel*DEPTH + fill] = r.push_value;
            fill_level[sel] = fill + 1;
          end
        end
        OP_POP, OP_PEEK: begin
          if (fill == 0) begin
            res.status     = ST_UNDERFLOW;
            res.read_value = '1;
          end else begin
            res.read_value = word_store[sel*DEPTH + fill - 1];
            if (r.opcode == OP_POP) fill_level[sel] = fill - 1;
          end
        end
        default: res.status = ST_INVALID;
      endcase
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cnt = ACTIVE_RST;
      for (int i = 0; i < NUM_CAPS; i++) cap_reg[i] = CAP_RST;
      for (int i = 0; i < NUM_STACKS; i++) fill_level[i] = 0;
      expected_q.delete();
      pending_o <= 0;
      errors_o  <= fails;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected response: read_value %0d status %0d",
                 rsp_data_i.read_value, rsp_data_i.status);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_data_i.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d",
                   want.read_value, rsp_data_i.read_value);
            fails++;
          end
          if (rsp_data_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_data_i.status);
            fails++;
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_q.push_back(apply_stack_op(req_data_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ACTIVE: active_cnt = cfg_wdata_i[ACTIVE_W-1:0];
          REG_CAP0:   cap_reg[0] = cfg_wdata_i[CAP_W-1:0];
          REG_CAP1:   cap_reg[1] = cfg_wdata_i[CAP_W-1:0];
          REG_CAP2:   cap_reg[2] = cfg_wdata_i[CAP_W-1:0];
          REG_CAP3:   cap_reg[3] = cfg_wdata_i[CAP_W-1:0];
          default: ;
        endcase
      end
      pending_o <= expected_q.size();
      errors_o  <= fails;
    end
  end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the multi-stack engine: directed corner cases,
// then random push/pop/peek traffic over several register settings and
// handshake idling patterns; the checker does all the comparing.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mse_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 300000;  // slowest legal run is far below this
  localparam int SETTLE_WAIT  = 4;       // pipeline plus margin
  localparam int NUM_PHASES   = 7;

  // Opcode value the package leaves unnamed; the engine must flag it invalid
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // Register settings per random phase; -1 means pick at random
  localparam int PHASE_ACTIVE [NUM_PHASES] = '{4, 1, 4, 7, 0, -1, -1};
  localparam int PHASE_CAPS [NUM_PHASES][NUM_CAPS] = '{
    '{16, 16, 16, 16},
    '{ 3, 31,  0,  5},
    '{ 0,  1, 31,  2},   // lowers capacities under fills left by earlier phases
    '{16, 31,  4, 16},
    '{16, 16, 16, 16},   // all indexes invalid in this phase
    '{-1, -1, -1, -1},
    '{-1, -1, -1, -1}
  };
  localparam int PHASE_ITEMS [NUM_PHASES] = '{65, 60, 65, 60, 20, 65, 65};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  rsp_ready = 1'b0;

  int          send_idle_pct = 0;   // chance per cycle that the sender holds off
  int          rsp_stall_pct = 0;   // chance per cycle that the receiver stalls
  int          pending;
  int          errors;
  int unsigned cycle_cnt = 0;

  // Random traffic shaping: long runs of pushes, then of pops, on one stack
  bit push_run     = 1'b1;
  int focus_stack  = 0;
  int active_now   = ACTIVE_RST;

  mse_stream_if #(.payload_t(req_t)) req_if ();
  mse_stream_if #(.payload_t(rsp_t)) rsp_if ();

  assign rsp_if.ready = rsp_ready;

  multi_stack_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .req_if      (req_if),
    .rsp_if      (rsp_if)
  );

  mse_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_data_i  (req_if.data),
    .rsp_valid_i (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_data_i  (rsp_if.data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // Hard stop: a hung handshake ends here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  function automatic req_t make_req(logic [OPCODE_W-1:0] op, int sel, logic [VALUE_W-1:0] val);
    req_t r;
    r.opcode       = op;
    r.stack_select = sel[SEL_W-1:0];
    r.push_value   = val;
    return r;
  endfunction

  // Mostly well-formed traffic aimed at one stack so that full and empty are
  // reached often; a small share goes to other or inactive stacks.
  function automatic req_t random_request();
    int                  span;
    int                  roll;
    int                  sel;
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0]  val;
    span = (active_now == 0 || active_now > NUM_STACKS_DEF) ? NUM_STACKS_DEF : active_now;
    if ($urandom_range(0, 23) == 0) begin
      push_run    = !push_run;
      focus_stack = $urandom_range(0, span - 1);
    end
    roll = $urandom_range(0, 99);
    if (roll < 70)      sel = focus_stack;
    else if (roll < 90) sel = $urandom_range(0, span - 1);
    else                sel = $urandom_range(0, NUM_STACKS_DEF - 1);
    roll = $urandom_range(0, 99);
    if (roll < 4)                          op = OP_UNUSED;
    else if (roll < (push_run ? 74 : 24))  op = OP_PUSH;
    else if (roll < (push_run ? 84 : 74))  op = OP_POP;
    else                                   op = OP_PEEK;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       val = 32'h7FFF_FFFF;
        1:       val = 32'h8000_0000;
        2:       val = '1;
        default: val = '0;
      endcase
    end else begin
      val = $urandom;
    end
    return make_req(op, sel, val);
  endfunction

  // One request transaction; valid stays high afterwards so back-to-back
  // transactions keep the channel busy. Idle gaps are drawn per cycle.
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Sender holds off until every predicted response has been seen
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Caller lowers the write enable after the last register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic load_config(input int act, input int c0, input int c1, input int c2,
                             input int c3);
    write_reg(REG_ACTIVE, act);
    write_reg(REG_CAP0, c0);
    write_reg(REG_CAP1, c1);
    write_reg(REG_CAP2, c2);
    write_reg(REG_CAP3, c3);
    cfg_we     <= 1'b0;
    active_now = act;
  endtask

  // Idling patterns: none, sender only, receiver only, both
  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct = 57; rsp_stall_pct <= 0;  end
      2:       begin send_idle_pct = 0;  rsp_stall_pct <= 57; end
      3:       begin send_idle_pct = 37; rsp_stall_pct <= 37; end
      default: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
    endcase
  endtask

  initial begin
    int act;
    int caps [NUM_CAPS];

    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_ACTIVE;
    cfg_wdata    <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, reset defaults: empty stacks, word extremes, bad opcode
    set_idling(0);
    send_request(make_req(OP_PEEK, 0, '0));            // underflow on peek
    send_request(make_req(OP_POP, 0, '0));             // underflow on pop
    send_request(make_req(OP_PUSH, 0, 32'h7FFF_FFFF));
    send_request(make_req(OP_PUSH, 0, 32'h8000_0000));
    send_request(make_req(OP_PEEK, 0, '0));
    send_request(make_req(OP_POP, 0, '0));
    send_request(make_req(OP_POP, 0, '0));
    send_request(make_req(OP_PUSH, 3, '1));
    send_request(make_req(OP_PUSH, 1, 32'h5555_5555));
    send_request(make_req(OP_PUSH, 2, 32'hAAAA_AAAA));
    send_request(make_req(OP_UNUSED, 1, '1));          // unused opcode
    send_request(make_req(OP_POP, 3, '0));
    send_request(make_req(OP_POP, 1, '0));
    send_request(make_req(OP_POP, 2, '0));
    drain();

    // --- directed, two active stacks; tiny and clamped capacities
    load_config(2, 2, 31, 0, 0);
    send_request(make_req(OP_PUSH, 0, '0));
    send_request(make_req(OP_PUSH, 0, 32'd1));
    send_request(make_req(OP_PUSH, 0, 32'd2));         // full stack
    send_request(make_req(OP_PUSH, 2, 32'd3));         // inactive index
    send_request(make_req(OP_PEEK, 3, '0));
    send_request(make_req(OP_POP, 1, '0));
    send_request(make_req(OP_PUSH, 1, 32'd5));
    send_request(make_req(OP_POP, 0, '0));
    send_request(make_req(OP_POP, 0, '0));
    send_request(make_req(OP_POP, 0, '0));
    drain();

    // --- random phases; registers change only with the engine idle
    for (int p = 0; p < NUM_PHASES; p++) begin
      act = (PHASE_ACTIVE[p] < 0) ? $urandom_range(1, 4) : PHASE_ACTIVE[p];
      for (int c = 0; c < NUM_CAPS; c++) begin
        caps[c] = (PHASE_CAPS[p][c] < 0) ? $urandom_range(0, 31) : PHASE_CAPS[p][c];
      end
      load_config(act, caps[0], caps[1], caps[2], caps[3]);
      set_idling((p + 1) % 4);
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (n == PHASE_ITEMS[p] / 2) drain();   // mid-phase pause, pipeline empties
        send_request(random_request());
      end
      drain();
    end

    repeat (SETTLE_WAIT) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
